[rtl/core/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and constants for the pixel format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

  // Palette size default; the top level may override it.
  localparam int PaletteEntriesDefault = 256;

  // Configuration register map (index = byte address / 4)
  localparam int CfgAddrW = 3;
  localparam logic RegSourceFormat = 1'b0;
  localparam logic RegDestDepth    = 1'b1;

  // Item commands
  localparam logic CmdConvert  = 1'b0;
  localparam logic CmdPalWrite = 1'b1;

  typedef enum logic [2:0] {
    FmtBgr24  = 3'd0,
    FmtRgb24  = 3'd1,
    FmtRgba32 = 3'd2,
    FmtAbgr32 = 3'd3,
    FmtArgb32 = 3'd4,
    FmtBgra32 = 3'd5,
    FmtIndex  = 3'd6
  } src_fmt_e;

  typedef enum logic [1:0] {
    Depth16 = 2'd0,
    Depth24 = 2'd1,
    Depth32 = 2'd2
  } depth_e;

  // RGB565 component masks
  localparam logic [7:0] Mask5 = 8'hf8;
  localparam logic [7:0] Mask6 = 8'hfc;

endpackage

[rtl/core/pfc_if.sv]
// ----------------------------------------------------------------------------
// pfc_if
// Valid/ready stream interfaces: source pixel items and converted results.
// ----------------------------------------------------------------------------
interface pfc_pix_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] px_byte0;
  logic [7:0] px_byte1;
  logic [7:0] px_byte2;
  logic [7:0] px_byte3;
  logic       last_in;
  logic [7:0] entry_index;
  logic [7:0] entry_red;
  logic [7:0] entry_green;
  logic [7:0] entry_blue;

  modport source (
    output valid, cmd, px_byte0, px_byte1, px_byte2, px_byte3, last_in,
           entry_index, entry_red, entry_green, entry_blue,
    input  ready
  );
  modport sink (
    input  valid, cmd, px_byte0, px_byte1, px_byte2, px_byte3, last_in,
           entry_index, entry_red, entry_green, entry_blue,
    output ready
  );
endinterface

interface pfc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_bytes;
  logic [2:0]  byte_count;
  logic        unsupported;
  logic        last_out;

  modport source (
    output valid, out_bytes, byte_count, unsupported, last_out,
    input  ready
  );
  modport sink (
    input  valid, out_bytes, byte_count, unsupported, last_out,
    output ready
  );
endinterface

[rtl/core/pixel_format_converter_top.sv]
// ----------------------------------------------------------------------------
// pixel_format_converter_top
// Converts one source pixel per transaction into display bytes, with palette.
// ----------------------------------------------------------------------------
// Usage
//   in_i  : source transactions. cmd 0 converts the pixel in px_byte0..3
//           (px_byte0 is the index for palette pixels); cmd 1 writes palette
//           entry entry_index and yields no result.
//   out_o : one result per convert transaction: out_bytes (first byte in
//           bits 7..0), byte_count, unsupported, last_out.
//   APB   : source_format at 0x0, dest_depth at 0x4. Write only when idle.
// Timing
//   A pixel taken at an edge enters the input stage (palette read issued
//   on the same edge) and moves on into the output register once that is
//   free. Throughput is one transaction per cycle while out_o is not held
//   off, set by the single palette read port feeding one compute stage.
// Reset
//   Both pipeline stages empty, registers back to BGR24 / 16 bits. The
//   palette is not cleared; entries must be written before they are used.
// Stalls
//   While out_o is held off the result stays put; the input stage still
//   refills, so ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module pixel_format_converter_top import pfc_pkg::*; #(
  parameter int PaletteEntries = PaletteEntriesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pfc_pix_if.sink             in_i,
  pfc_res_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AddrW = $clog2(PaletteEntries);
  localparam logic [8:0] EntriesLim = 9'(PaletteEntries);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0] src_fmt_q;
  logic [1:0] depth_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= FmtBgr24;
      depth_q   <= Depth16;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegSourceFormat: src_fmt_q <= pwdata[2:0];
        RegDestDepth:    depth_q   <= pwdata[1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegSourceFormat: prdata = {29'd0, src_fmt_q};
      RegDestDepth:    prdata = {30'd0, depth_q};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake control
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;   // output register can take a new result
  logic s1_adv;     // input stage moves into output register
  logic in_acc;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  // --------------------------------------------------------------------------
  // Palette: written and read on transaction acceptance
  // --------------------------------------------------------------------------
  logic        pal_we;
  logic        pal_re;
  logic [23:0] pal_rdata;

  assign pal_we = in_acc && (in_i.cmd == CmdPalWrite) &&
                  ({1'b0, in_i.entry_index} < EntriesLim);
  assign pal_re = in_acc && (in_i.cmd == CmdConvert);

  pfc_ram #(
    .Width (24),
    .Depth (PaletteEntries)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (in_i.entry_index[AddrW-1:0]),
    .wdata_i ({in_i.entry_blue, in_i.entry_green, in_i.entry_red}),
    .re_i    (pal_re),
    .raddr_i (in_i.px_byte0[AddrW-1:0]),
    .rdata_o (pal_rdata)
  );

  // --------------------------------------------------------------------------
  // Input stage
  // --------------------------------------------------------------------------
  logic [7:0] s1_b0_q, s1_b1_q, s1_b2_q, s1_b3_q;
  logic       s1_last_q;
  logic       s1_oor_q;  // palette index beyond the table: reads black

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= (in_i.cmd == CmdConvert);
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_re) begin
      s1_b0_q   <= in_i.px_byte0;
      s1_b1_q   <= in_i.px_byte1;
      s1_b2_q   <= in_i.px_byte2;
      s1_b3_q   <= in_i.px_byte3;
      s1_last_q <= in_i.last_in;
      s1_oor_q  <= ({1'b0, in_i.px_byte0} >= EntriesLim);
    end
  end

  // --------------------------------------------------------------------------
  // Conversion
  // --------------------------------------------------------------------------
  logic [7:0]  r, g, b;
  logic        have_rgb;
  logic [31:0] bytes_d;
  logic [2:0]  count_d;
  logic        bad_d;

  always_comb begin
    r        = '0;
    g        = '0;
    b        = '0;
    have_rgb = 1'b1;
    unique case (src_fmt_q)
      FmtBgr24, FmtBgra32: begin
        r = s1_b2_q; g = s1_b1_q; b = s1_b0_q;
      end
      FmtRgb24, FmtRgba32: begin
        r = s1_b0_q; g = s1_b1_q; b = s1_b2_q;
      end
      FmtAbgr32: begin
        r = s1_b3_q; g = s1_b2_q; b = s1_b1_q;
      end
      FmtArgb32: begin
        r = s1_b1_q; g = s1_b2_q; b = s1_b3_q;
      end
      FmtIndex: begin
        if (!s1_oor_q) begin
          r = pal_rdata[7:0]; g = pal_rdata[15:8]; b = pal_rdata[23:16];
        end
      end
      default: have_rgb = 1'b0;
    endcase
  end

  always_comb begin
    bytes_d = '0;
    bad_d   = 1'b0;
    count_d = 3'd4;
    unique case (depth_q)
      Depth16: begin
        count_d = 3'd2;
        if (have_rgb) begin
          bytes_d = {16'd0, r[7:3], g[7:2], b[7:3]};
        end else begin
          bad_d = 1'b1;
        end
      end
      Depth24: begin
        count_d = 3'd3;
        unique case (src_fmt_q)
          FmtBgr24, FmtRgb24: bytes_d = {8'd0, s1_b2_q, s1_b1_q, s1_b0_q};
          FmtIndex:           bytes_d = {8'd0, r, g, b};
          default:            bad_d   = 1'b1;
        endcase
      end
      Depth32: begin
        count_d = 3'd4;
        unique case (src_fmt_q)
          FmtRgba32, FmtAbgr32, FmtArgb32, FmtBgra32:
            bytes_d = {s1_b3_q, s1_b2_q, s1_b1_q, s1_b0_q};
          FmtBgr24, FmtRgb24: bytes_d = {8'd0, s1_b2_q, s1_b1_q, s1_b0_q};
          FmtIndex:           bytes_d = {8'd0, r, g, b};
          default:            bad_d   = 1'b1;
        endcase
      end
      default: bad_d = 1'b1;  // depth code 3
    endcase
    if (bad_d) begin
      bytes_d = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [31:0] out_bytes_q;
  logic [2:0]  out_count_q;
  logic        out_bad_q;
  logic        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_bytes_q <= bytes_d;
      out_count_q <= count_d;
      out_bad_q   <= bad_d;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_bytes   = out_bytes_q;
  assign out_o.byte_count  = out_count_q;
  assign out_o.unsupported = out_bad_q;
  assign out_o.last_out    = out_last_q;

`ifndef SYNTHESIS
  // A palette write never occupies the pipeline.
  a_palwr_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.cmd == CmdPalWrite) |=> !s1_valid_q)
    else $error("palette write entered the pipeline");

  // Backpressure only when both stages are full and the output is stalled.
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without cause");

  // An item leaving the input stage shows up at the output next cycle.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced item lost");

  // Unsupported results carry zero bytes.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_bad_q |-> out_bytes_q == 32'd0)
    else $error("unsupported result with non-zero bytes");

  // Byte count is always 2, 3 or 4.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_count_q == 3'd2 || out_count_q == 3'd3 || out_count_q == 3'd4)
    else $error("byte count out of range");
`endif

endmodule

[rtl/core/pfc_ram.sv]
// ----------------------------------------------------------------------------
// pfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfc_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
